[sv/vaa_pkg.sv]
// ----------------------------------------------------------------------------
// vaa_pkg - shared types and constants for the vector angle block
// Datapath widths, binary-angle constants, arctangent table, unit scaling
// factors and the control word that travels down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vaa_pkg;

  // defaults for the top-level parameters
  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int CORDIC_STAGES_DEF   = 16;

  // CORDIC x/y datapath (holds |a||b| * 2^29 times the CORDIC gain)
  localparam int DATA_W  = 63;
  // binary angle accumulator, 2^32 is one full turn
  localparam int ZACC_W  = 33;
  // magnitude of the clamped angle
  localparam int MAG_W   = 32;
  // scaling product
  localparam int PROD_W  = 63;
  // result angle field
  localparam int ANGLE_W = 15;
  // bit position the products are aligned to
  localparam int ALIGN_POS = 61;

  localparam logic signed [ZACC_W-1:0] HALF_TURN    = 33'sh0_8000_0000;
  localparam logic signed [ZACC_W-1:0] QUARTER_TURN = 33'sh0_4000_0000;

  // unit scaling: radians use round(pi*2^29) / 2^48, degrees 45 / 2^23
  localparam int MUL_W = 31;
  localparam logic [MUL_W-1:0] RAD_MUL   = 31'd1686629713;
  localparam logic [MUL_W-1:0] DEG_MUL   = 31'd45;
  localparam int               RAD_SHIFT = 48;
  localparam int               DEG_SHIFT = 23;

  // round(atan(2^-i) * 2^32 / 2pi)
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // angle unit register codes
  typedef enum logic {
    UNIT_RAD = 1'b0,
    UNIT_DEG = 1'b1
  } vaa_unit_t;

  // per-stage control word
  typedef struct packed {
    logic valid;     // stage holds a request
    logic zero_vec;  // one of the vectors is (0,0)
    logic fixed;     // angle settled on an axis, CORDIC passes it through
  } vaa_ctl_t;

endpackage

`default_nettype wire

[sv/vaa_cordic_stage.sv]
// ----------------------------------------------------------------------------
// vaa_cordic_stage - one registered CORDIC vectoring iteration
// Rotates (x, y) towards the positive x axis by atan(2^-IDX) and updates the
// binary angle accumulator. Settled requests pass through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module vaa_cordic_stage
  import vaa_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire vaa_ctl_t                  ctl_i,
  input  wire logic signed [DATA_W-1:0]  x_i,
  input  wire logic signed [DATA_W-1:0]  y_i,
  input  wire logic signed [ZACC_W-1:0]  z_i,
  output vaa_ctl_t                       ctl_o,
  output logic signed [DATA_W-1:0]       x_o,
  output logic signed [DATA_W-1:0]       y_o,
  output logic signed [ZACC_W-1:0]       z_o
);

  vaa_ctl_t                  ctl_r;
  logic signed [DATA_W-1:0]  x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [ZACC_W-1:0]  z_r, z_nxt, step;

  // floor shifts and the angle step of this iteration
  assign dx   = y_i >>> IDX;
  assign dy   = x_i >>> IDX;
  assign step = $signed({1'b0, ATAN_TURNS[IDX]});

  // rotate by the sign of y
  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (!ctl_i.fixed) begin
      if (!y_i[DATA_W-1]) begin
        x_nxt = x_i + dx;
        y_nxt = y_i - dy;
        z_nxt = z_i + step;
      end else begin
        x_nxt = x_i - dx;
        y_nxt = y_i + dy;
        z_nxt = z_i - step;
      end
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

[sv/vector_angle_atan2.sv]
// ----------------------------------------------------------------------------
// vector_angle_atan2 - signed angle between two planar vectors
// atan2(cross, dot) by a fully unrolled CORDIC in vectoring mode, scaled to
// radians (Q3.12) or degrees (Q9.6) as the angle_unit register selects.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  --------------------------------
//  in       sink       in_valid / in_stall  in_a_x, in_a_y, in_b_x, in_b_y
//  out      source     out_valid/out_stall  out_angle, out_zero_vector
//  cfg      sink       cfg_valid/cfg_ready  cfg_data (angle_unit)
//
//  One request per cycle while the output is not stalled; the registers are:
//  product, cross/dot sum, quadrant fold, one register per CORDIC iteration,
//  clamp, unit multiply, rounding into the output register.
//  Each stage moves on when it is empty or the stage after it moves, so a
//  stalled output only holds back requests behind it and bubbles close up.
//  Synchronous reset clears all valid bits and sets the unit to radians.
//
`default_nettype none

module vector_angle_atan2
  import vaa_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input requests
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_a_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_a_y,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_b_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_b_y,
  // results
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [ANGLE_W-1:0]              out_angle,
  output logic                                   out_zero_vector,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [0:0]                        cfg_data
);

  localparam int PW = 2 * COMPONENT_WIDTH;
  localparam int NS = CORDIC_STAGES + 6;

  // stage indices
  localparam int ST_P = 0;
  localparam int ST_S = 1;
  localparam int ST_F = 2;
  localparam int ST_A = CORDIC_STAGES + 3;
  localparam int ST_B = CORDIC_STAGES + 4;
  localparam int ST_C = CORDIC_STAGES + 5;

  vaa_unit_t angle_unit_r;
  logic      unit_deg;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_unit_r <= UNIT_RAD;
    end else if (cfg_valid) begin
      angle_unit_r <= vaa_unit_t'(cfg_data[0]);
    end
  end

  assign unit_deg = (angle_unit_r == UNIT_DEG);

  // per-stage advance, bubbles collapse
  assign en[NS-1] = !vld[NS-1] || !out_stall;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign in_stall = !en[ST_P];

  // ---- stage P: four products and zero-vector detect ----
  vaa_ctl_t                 ctl_p_r, ctl_p_nxt;
  logic signed [PW-1:0]     p1_r, p2_r, p3_r, p4_r;

  always_comb begin
    ctl_p_nxt.valid    = in_valid;
    ctl_p_nxt.zero_vec = ((in_a_x == '0) && (in_a_y == '0)) ||
                         ((in_b_x == '0) && (in_b_y == '0));
    ctl_p_nxt.fixed    = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p_r <= '0;
    end else if (en[ST_P]) begin
      ctl_p_r <= ctl_p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_P]) begin
      p1_r <= PW'(in_a_x) * PW'(in_b_y);
      p2_r <= PW'(in_a_y) * PW'(in_b_x);
      p3_r <= PW'(in_a_x) * PW'(in_b_x);
      p4_r <= PW'(in_a_y) * PW'(in_b_y);
    end
  end

  // ---- stage S: cross and dot, aligned to the CORDIC datapath ----
  vaa_ctl_t                 ctl_s_r;
  logic signed [DATA_W-1:0] cross_nxt, dot_nxt, cross_r, dot_r;

  if (PW <= ALIGN_POS) begin : g_shl
    localparam int LSH = ALIGN_POS - PW;
    logic signed [PW:0] cross_w, dot_w;
    assign cross_w   = {p1_r[PW-1], p1_r} - {p2_r[PW-1], p2_r};
    assign dot_w     = {p3_r[PW-1], p3_r} + {p4_r[PW-1], p4_r};
    assign cross_nxt = DATA_W'(cross_w) <<< LSH;
    assign dot_nxt   = DATA_W'(dot_w) <<< LSH;
  end else begin : g_shr
    // wide components: floor-shift each product before the sum
    localparam int RSH = PW - ALIGN_POS;
    logic signed [PW-1:0] q1, q2, q3, q4;
    assign q1        = p1_r >>> RSH;
    assign q2        = p2_r >>> RSH;
    assign q3        = p3_r >>> RSH;
    assign q4        = p4_r >>> RSH;
    assign cross_nxt = DATA_W'(q1) - DATA_W'(q2);
    assign dot_nxt   = DATA_W'(q3) + DATA_W'(q4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s_r <= '0;
    end else if (en[ST_S]) begin
      ctl_s_r <= ctl_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_S]) begin
      cross_r <= cross_nxt;
      dot_r   <= dot_nxt;
    end
  end

  // ---- stage F: axis cases and left half-plane fold ----
  vaa_ctl_t                 ctl_f_r, ctl_f_nxt;
  logic signed [DATA_W-1:0] x_f_r, y_f_r, x_f_nxt, y_f_nxt;
  logic signed [ZACC_W-1:0] z_f_r, z_f_nxt;

  always_comb begin
    ctl_f_nxt       = ctl_s_r;
    ctl_f_nxt.fixed = 1'b0;
    x_f_nxt         = dot_r;
    y_f_nxt         = cross_r;
    z_f_nxt         = '0;
    if (cross_r == '0) begin
      // on the x axis
      ctl_f_nxt.fixed = 1'b1;
      z_f_nxt         = dot_r[DATA_W-1] ? HALF_TURN : '0;
    end else if (dot_r == '0) begin
      // on the y axis
      ctl_f_nxt.fixed = 1'b1;
      z_f_nxt         = cross_r[DATA_W-1] ? -QUARTER_TURN : QUARTER_TURN;
    end else if (dot_r[DATA_W-1]) begin
      // left half plane: turn by a quarter first
      if (!cross_r[DATA_W-1]) begin
        x_f_nxt = cross_r;
        y_f_nxt = -dot_r;
        z_f_nxt = QUARTER_TURN;
      end else begin
        x_f_nxt = -cross_r;
        y_f_nxt = dot_r;
        z_f_nxt = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_f_r <= '0;
    end else if (en[ST_F]) begin
      ctl_f_r <= ctl_f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_F]) begin
      x_f_r <= x_f_nxt;
      y_f_r <= y_f_nxt;
      z_f_r <= z_f_nxt;
    end
  end

  // ---- CORDIC iterations, one register each ----
  vaa_ctl_t                 cctl [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0] cx   [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0] cy   [CORDIC_STAGES+1];
  logic signed [ZACC_W-1:0] cz   [CORDIC_STAGES+1];

  assign cctl[0] = ctl_f_r;
  assign cx[0]   = x_f_r;
  assign cy[0]   = y_f_r;
  assign cz[0]   = z_f_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    vaa_cordic_stage #(
      .IDX (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en[ST_F+1+i]),
      .ctl_i (cctl[i]),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .ctl_o (cctl[i+1]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
    assign vld[ST_F+1+i] = cctl[i+1].valid;
  end

  // ---- stage A: clamp to half a turn, split sign and magnitude ----
  vaa_ctl_t                 ctl_a_r;
  logic signed [ZACC_W-1:0] z_cl, z_abs;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;

  always_comb begin
    z_cl = cz[CORDIC_STAGES];
    if (z_cl > HALF_TURN) begin
      z_cl = HALF_TURN;
    end else if (z_cl < -HALF_TURN) begin
      z_cl = -HALF_TURN;
    end
    z_abs = z_cl[ZACC_W-1] ? -z_cl : z_cl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (en[ST_A]) begin
      ctl_a_r <= cctl[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      mag_r <= z_abs[MAG_W-1:0];
      neg_r <= z_cl[ZACC_W-1];
    end
  end

  // ---- stage B: unit scaling multiply ----
  vaa_ctl_t          ctl_b_r;
  logic [MUL_W-1:0]  mul_k;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              neg_b_r;

  assign mul_k    = unit_deg ? DEG_MUL : RAD_MUL;
  assign prod_nxt = PROD_W'(mag_r) * PROD_W'(mul_k);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (en[ST_B]) begin
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_B]) begin
      prod_r  <= prod_nxt;
      neg_b_r <= neg_r;
    end
  end

  // ---- stage C: round half up on the magnitude, restore sign ----
  vaa_ctl_t                 ctl_c_r;
  logic [PROD_W:0]          rnd, sum_v, shr_v;
  logic [ANGLE_W-1:0]       res_mag;
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;

  always_comb begin
    rnd       = unit_deg ? ((PROD_W+1)'(1) << (DEG_SHIFT - 1))
                         : ((PROD_W+1)'(1) << (RAD_SHIFT - 1));
    sum_v     = {1'b0, prod_r} + rnd;
    shr_v     = unit_deg ? (sum_v >> DEG_SHIFT) : (sum_v >> RAD_SHIFT);
    res_mag   = shr_v[ANGLE_W-1:0];
    angle_nxt = neg_b_r ? -$signed(res_mag) : $signed(res_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
    end else if (en[ST_C]) begin
      ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      angle_r <= angle_nxt;
    end
  end

  // valid bits of the stages kept here
  assign vld[ST_P] = ctl_p_r.valid;
  assign vld[ST_S] = ctl_s_r.valid;
  assign vld[ST_F] = ctl_f_r.valid;
  assign vld[ST_A] = ctl_a_r.valid;
  assign vld[ST_B] = ctl_b_r.valid;
  assign vld[ST_C] = ctl_c_r.valid;

  // outputs
  assign out_valid       = ctl_c_r.valid;
  assign out_angle       = angle_r;
  assign out_zero_vector = ctl_c_r.zero_vec;

endmodule

`default_nettype wire
